// ===== rtl/tdpt_pkg.sv =====
// shared constants, types and the sequencer program of the trial division prime test
package tdpt_pkg;

  // operand sizing
  localparam int VALUE_BITS = 16;
  localparam int D_BITS     = (VALUE_BITS + 1) / 2 + 1;
  localparam int SQ_BITS    = 2 * D_BITS;
  localparam int CNT_BITS   = $clog2(VALUE_BITS);
  localparam int STEP_BITS  = 3;

  typedef logic [STEP_BITS-1:0] step_t;

  // program addresses
  localparam step_t ST_WAIT  = 3'd0;
  localparam step_t ST_LOW   = 3'd1;
  localparam step_t ST_SQ    = 3'd2;
  localparam step_t ST_BOUND = 3'd3;
  localparam step_t ST_DIV   = 3'd4;
  localparam step_t ST_REM   = 3'd5;
  localparam step_t ST_DONE  = 3'd6;

  // datapath operation of one step
  typedef enum logic [2:0] {
    OP_WAIT,
    OP_LOW,
    OP_SQUARE,
    OP_BOUND,
    OP_DIV,
    OP_REM,
    OP_DONE
  } op_e;

  // branch condition of one step
  typedef enum logic [2:0] {
    COND_ACCEPT,
    COND_LOW,
    COND_OVER,
    COND_LAST,
    COND_REM_ZERO,
    COND_OUT_FREE,
    COND_ALWAYS
  } cond_e;

  // one control word
  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t jump_t;
    step_t jump_f;
  } ucode_t;

  // datapath controls
  typedef struct packed {
    logic load;
    logic init_d;
    logic square;
    logic div_init;
    logic div_step;
    logic inc_d;
  } dp_ctrl_t;

  // datapath status
  typedef struct packed {
    logic low;
    logic over;
    logic last;
    logic rem_zero;
  } dp_stat_t;

  // control store
  function automatic ucode_t ucode_rom(input step_t addr);
    ucode_t w;
    unique case (addr)
      ST_WAIT:  w = '{op: OP_WAIT,   cond: COND_ACCEPT,   jump_t: ST_LOW,   jump_f: ST_WAIT};
      ST_LOW:   w = '{op: OP_LOW,    cond: COND_LOW,      jump_t: ST_DONE,  jump_f: ST_SQ};
      ST_SQ:    w = '{op: OP_SQUARE, cond: COND_ALWAYS,   jump_t: ST_BOUND, jump_f: ST_BOUND};
      ST_BOUND: w = '{op: OP_BOUND,  cond: COND_OVER,     jump_t: ST_DONE,  jump_f: ST_DIV};
      ST_DIV:   w = '{op: OP_DIV,    cond: COND_LAST,     jump_t: ST_REM,   jump_f: ST_DIV};
      ST_REM:   w = '{op: OP_REM,    cond: COND_REM_ZERO, jump_t: ST_DONE,  jump_f: ST_SQ};
      ST_DONE:  w = '{op: OP_DONE,   cond: COND_OUT_FREE, jump_t: ST_WAIT,  jump_f: ST_DONE};
      default:  w = '{op: OP_DONE,   cond: COND_ALWAYS,   jump_t: ST_WAIT,  jump_f: ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/tdpt_datapath.sv =====
// value, divisor, square and bit-serial remainder registers
module tdpt_datapath import tdpt_pkg::*; (
  input  logic                  clk_i,
  input  dp_ctrl_t              ctrl_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output dp_stat_t              stat_o
);

  logic [VALUE_BITS-1:0] v_q, v_d;
  logic [D_BITS-1:0]     d_q, d_d;
  logic [SQ_BITS-1:0]    sq_q, sq_d;
  logic [D_BITS-1:0]     r_q, r_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [D_BITS:0]       shifted;
  logic [D_BITS:0]       d_ext;

  // one restoring division step per cycle, msb of the value first
  assign shifted = {r_q, v_q[cnt_q]};
  assign d_ext   = {1'b0, d_q};

  always_comb begin
    v_d   = v_q;
    d_d   = d_q;
    sq_d  = sq_q;
    r_d   = r_q;
    cnt_d = cnt_q;
    if (ctrl_i.load) begin
      v_d = value_i;
    end
    if (ctrl_i.init_d) begin
      d_d = D_BITS'(2);
    end
    if (ctrl_i.inc_d) begin
      d_d = d_q + 1'b1;
    end
    if (ctrl_i.square) begin
      sq_d = SQ_BITS'(d_q) * SQ_BITS'(d_q);
    end
    if (ctrl_i.div_init) begin
      r_d   = '0;
      cnt_d = CNT_BITS'(VALUE_BITS - 1);
    end
    if (ctrl_i.div_step) begin
      if (shifted >= d_ext) begin
        r_d = D_BITS'(shifted - d_ext);
      end else begin
        r_d = shifted[D_BITS-1:0];
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  // operand registers carry no reset
  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    d_q   <= d_d;
    sq_q  <= sq_d;
    r_q   <= r_d;
    cnt_q <= cnt_d;
  end

  // status back to the sequencer
  assign stat_o.low      = (v_q < VALUE_BITS'(2));
  assign stat_o.over     = (sq_q > SQ_BITS'(v_q));
  assign stat_o.last     = (cnt_q == '0);
  assign stat_o.rem_zero = (r_q == '0);

endmodule

// ===== rtl/trial_division_prime_test.sv =====
// trial division prime test: microcoded sequencer, datapath and output register
// each divisor costs one square, one bound check, VALUE_BITS remainder steps and one test
// throughput: one item at a time; the next item is taken in the cycle after the result
//   moves to the output register, which holds it while the far side stalls
// reset: asynchronous, returns the sequencer to its wait step and empties the output register
module trial_division_prime_test import tdpt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  is_prime_o
);

  step_t    pc_q, pc_d;
  ucode_t   uw;
  dp_ctrl_t ctrl;
  dp_stat_t stat;
  logic     accept;
  logic     out_free;
  logic     cond_hit;
  logic     res_q, res_d;
  logic     out_valid_q, out_valid_d;
  logic     is_prime_q, is_prime_d;

  // fetch the current control word
  assign uw = ucode_rom(pc_q);

  assign in_stall_o = (uw.op != OP_WAIT);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // branch condition select
  always_comb begin
    unique case (uw.cond)
      COND_ACCEPT:   cond_hit = accept;
      COND_LOW:      cond_hit = stat.low;
      COND_OVER:     cond_hit = stat.over;
      COND_LAST:     cond_hit = stat.last;
      COND_REM_ZERO: cond_hit = stat.rem_zero;
      COND_OUT_FREE: cond_hit = out_free;
      COND_ALWAYS:   cond_hit = 1'b1;
      default:       cond_hit = 1'b1;
    endcase
  end

  assign pc_d = cond_hit ? uw.jump_t : uw.jump_f;

  // decode the operation into datapath controls and the verdict
  always_comb begin
    ctrl  = '0;
    res_d = res_q;
    unique case (uw.op)
      OP_WAIT: begin
        ctrl.load = accept;
      end
      OP_LOW: begin
        ctrl.init_d = 1'b1;
        if (stat.low) begin
          res_d = 1'b0;
        end
      end
      OP_SQUARE: begin
        ctrl.square = 1'b1;
      end
      OP_BOUND: begin
        ctrl.div_init = 1'b1;
        if (stat.over) begin
          res_d = 1'b1;
        end
      end
      OP_DIV: begin
        ctrl.div_step = 1'b1;
      end
      OP_REM: begin
        ctrl.inc_d = 1'b1;
        if (stat.rem_zero) begin
          res_d = 1'b0;
        end
      end
      OP_DONE: begin
        ctrl = '0;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  tdpt_datapath u_datapath (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .value_i (value_i),
    .stat_o  (stat)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    is_prime_d  = is_prime_q;
    if (uw.op == OP_DONE && out_free) begin
      out_valid_d = 1'b1;
      is_prime_d  = res_q;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= ST_WAIT;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // verdict and result payload
  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    is_prime_q <= is_prime_d;
  end

  assign out_valid_o = out_valid_q;
  assign is_prime_o  = is_prime_q;

endmodule
